>>> src/bounded_double_ended_list_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded double-ended list
// Shorthands for clocked implication checks that are quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_LIST_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDEL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bdel_pkg.sv
// ----------------------------------------------------------------------------
// bdel_pkg
// Shared types, operation and status codes for the bounded double-ended list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdel_pkg;

  localparam int CAPACITY_DEF     = 256;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int OP_W       = 3;
  localparam int ELEM_FW    = 32;
  localparam int POS_W      = 8;
  localparam int COUNT_FW   = 9;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_RM_HEAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_RM_TAIL  = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_HEAD  = 3'd4;
  localparam logic [OP_W-1:0] OP_RD_TAIL  = 3'd5;
  localparam logic [OP_W-1:0] OP_RD_INDEX = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ELEM_FW-1:0] element_in;
    logic [POS_W-1:0]   position;
  } req_word_t;

  typedef struct packed {
    logic [ELEM_FW-1:0]  element_out;
    logic [COUNT_FW-1:0] count_out;
    logic [STATUS_W-1:0] status;
  } rsp_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_r;
    logic shift_l;
    logic wr_en;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> src/bounded_double_ended_list.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_list
// Bounded double-ended list of element words held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (op, element_in, position) enters on req when req_valid is
//   high and req_stall is low. Each request gives exactly one response word
//   (element_out, count_out, status) on rsp, held until rsp_stall is low.
//   The list lives in a chain of CAPACITY cells with the head in cell 0.
//   Inserts, removes, a read of the head and every failing operation finish
//   in the accept cycle; the response is registered and shows in the next
//   cycle, and a new request is taken every cycle while responses drain.
//   A read of the tail or of a position rotates the occupied cells one step
//   a cycle until the list is back in order, capturing the wanted word on
//   the way; req_stall stays high until the rotation is done.
//   While the response register is full and stalled, req_stall stays high.
//   Reset empties the list and drops any pending response; cell contents
//   are not cleared and need no clearing pass, since reads are checked
//   against the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_double_ended_list_assert.svh"

module bounded_double_ended_list #(
  parameter int CAPACITY     = bdel_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = bdel_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire bdel_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output bdel_pkg::rsp_word_t      rsp
);

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = bdel_pkg::POS_W;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ELEM_FW  = bdel_pkg::ELEM_FW;
  localparam int COUNT_FW = bdel_pkg::COUNT_FW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_ROT  = 1'b1;

  logic                      state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [IDX_W-1:0]          step, step_next;
  logic [IDX_W-1:0]          target, target_next;
  logic [ELEMENT_BITS-1:0]   held, held_next;

  bdel_pkg::cell_cmd_t       cmd;
  logic [IDX_W-1:0]          wr_idx;
  logic [ELEMENT_BITS-1:0]   wr_data;
  logic [ELEMENT_BITS-1:0]   head_val;
  logic [ELEMENT_BITS-1:0]   elem_in;

  logic                      load;
  logic [ELEMENT_BITS-1:0]   res_elem;
  logic [bdel_pkg::STATUS_W-1:0] res_status;

  logic                      req_acc;
  logic                      rsp_take;
  logic                      full;
  logic                      empty;
  logic [CNT_W-1:0]          cnt_m1;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          cnt_ext;

  assign req_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign req_acc   = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;

  assign elem_in = ELEMENT_BITS'(req.element_in);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign cnt_m1  = count - CNT_W'(1);
  assign pos_ext = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count);

  always_comb begin
    state_next  = state;
    count_next  = count;
    step_next   = step;
    target_next = target;
    held_next   = held;
    cmd         = '0;
    wr_idx      = '0;
    wr_data     = elem_in;
    load        = 1'b0;
    res_elem    = '0;
    res_status  = bdel_pkg::ST_OK;

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          load = 1'b1;
          unique case (req.op)
            bdel_pkg::OP_INS_HEAD: begin
              if (full) begin
                res_status = bdel_pkg::ST_FULL;
              end else begin
                cmd.shift_r = 1'b1;
                count_next  = count + CNT_W'(1);
              end
            end
            bdel_pkg::OP_INS_TAIL: begin
              if (full) begin
                res_status = bdel_pkg::ST_FULL;
              end else begin
                cmd.wr_en  = 1'b1;
                wr_idx     = count[IDX_W-1:0];
                count_next = count + CNT_W'(1);
              end
            end
            bdel_pkg::OP_RM_HEAD: begin
              if (empty) begin
                res_status = bdel_pkg::ST_EMPTY;
              end else begin
                cmd.shift_l = 1'b1;
                count_next  = cnt_m1;
              end
            end
            bdel_pkg::OP_RM_TAIL: begin
              if (empty) begin
                res_status = bdel_pkg::ST_EMPTY;
              end else begin
                count_next = cnt_m1;
              end
            end
            bdel_pkg::OP_RD_HEAD: begin
              if (empty) begin
                res_status = bdel_pkg::ST_EMPTY;
              end else begin
                res_elem = head_val;
              end
            end
            bdel_pkg::OP_RD_TAIL: begin
              if (empty) begin
                res_status = bdel_pkg::ST_EMPTY;
              end else begin
                load        = 1'b0;
                state_next  = S_ROT;
                step_next   = '0;
                target_next = cnt_m1[IDX_W-1:0];
              end
            end
            bdel_pkg::OP_RD_INDEX: begin
              if (empty) begin
                res_status = bdel_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status = bdel_pkg::ST_RANGE;
              end else begin
                load        = 1'b0;
                state_next  = S_ROT;
                step_next   = '0;
                target_next = pos_ext[IDX_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ROT: begin
        // Rotate the occupied cells by one: the head word wraps to the tail.
        // After count steps the list is back in its original order.
        cmd.shift_l = 1'b1;
        cmd.wr_en   = 1'b1;
        wr_idx      = cnt_m1[IDX_W-1:0];
        wr_data     = head_val;
        if (step == target) begin
          held_next = head_val;
        end
        if (step == cnt_m1[IDX_W-1:0]) begin
          state_next = S_IDLE;
          load       = 1'b1;
          res_elem   = (step == target) ? head_val : held;
        end else begin
          step_next = step + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step   <= step_next;
    target <= target_next;
    held   <= held_next;
    if (load) begin
      rsp.element_out <= ELEM_FW'(res_elem);
      rsp.count_out   <= COUNT_FW'(count_next);
      rsp.status      <= res_status;
    end
  end

  bdel_chain #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .head_val (head_val)
  );

  `BDEL_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count beyond capacity")
  `BDEL_ASSERT_SAME(a_rot_no_rsp, state == S_ROT, !rsp_valid, "response pending while rotating")
  `BDEL_ASSERT_NEXT(a_rot_count, state == S_ROT, count == $past(count), "count changed by a read")
  `BDEL_ASSERT_NEXT(a_short_rsp, req_acc && (req.op != bdel_pkg::OP_RD_TAIL) && (req.op != bdel_pkg::OP_RD_INDEX), rsp_valid, "no response after a one-cycle operation")

endmodule

`default_nettype wire

>>> src/bdel_cell.sv
// ----------------------------------------------------------------------------
// bdel_cell
// One element slot of the chain; takes a neighbor's value or a write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdel_cell #(
  parameter int CAPACITY     = bdel_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = bdel_pkg::ELEMENT_BITS_DEF,
  parameter int INDEX        = 0
) (
  input  wire logic                        clk,
  input  wire bdel_pkg::cell_cmd_t         cmd,
  input  wire logic [$clog2(CAPACITY)-1:0] wr_idx,
  input  wire logic [ELEMENT_BITS-1:0]     wr_data,
  input  wire logic [ELEMENT_BITS-1:0]     left_val,
  input  wire logic [ELEMENT_BITS-1:0]     right_val,
  output logic      [ELEMENT_BITS-1:0]     val
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ELEMENT_BITS-1:0] val_next;

  always_comb begin
    priority if (cmd.shift_r) begin
      val_next = left_val;
    end else if (cmd.wr_en && (wr_idx == MY_IDX)) begin
      val_next = wr_data;
    end else if (cmd.shift_l) begin
      val_next = right_val;
    end else begin
      val_next = val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

>>> src/bdel_chain.sv
// ----------------------------------------------------------------------------
// bdel_chain
// Row of element cells; cell 0 holds the head of the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdel_chain #(
  parameter int CAPACITY     = bdel_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = bdel_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire bdel_pkg::cell_cmd_t         cmd,
  input  wire logic [$clog2(CAPACITY)-1:0] wr_idx,
  input  wire logic [ELEMENT_BITS-1:0]     wr_data,
  output logic      [ELEMENT_BITS-1:0]     head_val
);

  logic [ELEMENT_BITS-1:0] vals [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_val;
    logic [ELEMENT_BITS-1:0] right_val;

    // A shift toward the tail feeds the write word into cell 0.
    if (i == 0) begin : g_first
      assign left_val = wr_data;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    bdel_cell #(
      .CAPACITY     (CAPACITY),
      .ELEMENT_BITS (ELEMENT_BITS),
      .INDEX        (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[i])
    );
  end

  assign head_val = vals[0];

endmodule

`default_nettype wire

>>> sim/bounded_double_ended_list_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bounded double-ended list
// A short table of directed words covers the empty, full-range and index
// cases. Random traffic then fills the list to capacity and drains it again.
// Both sides idle at random, and the receiver holds off once for a long
// stretch. Every response word is checked against a ring-buffer predictor.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_test;

  localparam int CAP          = bdel_pkg::CAPACITY_DEF;
  localparam int OP_W         = bdel_pkg::OP_W;
  localparam int ELEM_FW      = bdel_pkg::ELEM_FW;
  localparam int POS_W        = bdel_pkg::POS_W;
  localparam int COUNT_FW     = bdel_pkg::COUNT_FW;
  localparam int STATUS_W     = bdel_pkg::STATUS_W;
  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 500;
  localparam int DRAIN_CYCLES = 2 * CAP + 40;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_CAP    = 40;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef enum logic [1:0] {TREND_GROW, TREND_SHRINK, TREND_MIX} trend_t;

  typedef struct {
    bdel_pkg::req_word_t word;
    bit                  fixed;
    bdel_pkg::rsp_word_t want;
  } probe_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  bdel_pkg::req_word_t req_word = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  bdel_pkg::rsp_word_t rsp_word;

  // Predictor state: a ring of element words with a head slot and a fill.
  logic [ELEM_FW-1:0]  ring_words [CAP];
  logic [POS_W-1:0]    ring_head = '0;
  logic [COUNT_FW-1:0] ring_fill = '0;

  bdel_pkg::rsp_word_t pending_q [$];
  probe_t              probe_q [$];
  int                  miss_cnt = 0;
  int                  checked_cnt = 0;
  int                  quiet_cycles = 0;
  trend_t              trend = TREND_GROW;

  bounded_double_ended_list u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_word)
  );

  always #6 clk = ~clk;

  // Applies one word to the ring and returns the response it should give.
  function automatic bdel_pkg::rsp_word_t apply_list_op(input bdel_pkg::req_word_t w);
    bdel_pkg::rsp_word_t r;
    r = '0;
    case (w.op)
      bdel_pkg::OP_INS_HEAD, bdel_pkg::OP_INS_TAIL: begin
        if (ring_fill == CAP) begin
          r.status = bdel_pkg::ST_FULL;
        end else if (w.op == bdel_pkg::OP_INS_HEAD) begin
          ring_head = ring_head - 1'b1;
          ring_words[ring_head] = w.element_in;
          ring_fill = ring_fill + 1'b1;
        end else begin
          ring_words[POS_W'(ring_head + ring_fill)] = w.element_in;
          ring_fill = ring_fill + 1'b1;
        end
      end
      bdel_pkg::OP_RM_HEAD, bdel_pkg::OP_RM_TAIL: begin
        if (ring_fill == 0) begin
          r.status = bdel_pkg::ST_EMPTY;
        end else begin
          if (w.op == bdel_pkg::OP_RM_HEAD) ring_head = ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
        end
      end
      bdel_pkg::OP_RD_HEAD, bdel_pkg::OP_RD_TAIL, bdel_pkg::OP_RD_INDEX: begin
        if (ring_fill == 0) begin
          r.status = bdel_pkg::ST_EMPTY;
        end else if (w.op == bdel_pkg::OP_RD_HEAD) begin
          r.element_out = ring_words[ring_head];
        end else if (w.op == bdel_pkg::OP_RD_TAIL) begin
          r.element_out = ring_words[POS_W'(ring_head + ring_fill - 1'b1)];
        end else if (COUNT_FW'(w.position) >= ring_fill) begin
          r.status = bdel_pkg::ST_RANGE;
        end else begin
          r.element_out = ring_words[POS_W'(ring_head + w.position)];
        end
      end
      default: begin
      end
    endcase
    r.count_out = ring_fill;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a steady run.
  function automatic int pick_gap(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] pick_read();
    int roll;
    roll = $urandom_range(0, 2);
    if (roll == 0) return bdel_pkg::OP_RD_HEAD;
    if (roll == 1) return bdel_pkg::OP_RD_TAIL;
    return bdel_pkg::OP_RD_INDEX;
  endfunction

  // Draws a random word whose mix of operations follows the current trend.
  function automatic bdel_pkg::req_word_t draw_word();
    bdel_pkg::req_word_t w;
    int                  roll;
    w.element_in = $urandom();
    w.position   = POS_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (trend == TREND_MIX) begin
      w.op = OP_W'($urandom_range(0, 7));
    end else if (roll < 70) begin
      if (trend == TREND_GROW)
        w.op = (roll < 35) ? bdel_pkg::OP_INS_HEAD : bdel_pkg::OP_INS_TAIL;
      else w.op = (roll < 35) ? bdel_pkg::OP_RM_HEAD : bdel_pkg::OP_RM_TAIL;
    end else if (roll < 80) begin
      if (trend == TREND_GROW)
        w.op = (roll < 75) ? bdel_pkg::OP_RM_HEAD : bdel_pkg::OP_RM_TAIL;
      else w.op = (roll < 75) ? bdel_pkg::OP_INS_HEAD : bdel_pkg::OP_INS_TAIL;
    end else begin
      w.op = pick_read();
    end
    // Most indexed reads land inside the list.
    if (w.op == bdel_pkg::OP_RD_INDEX && ring_fill != 0 && $urandom_range(0, 99) < 85)
      w.position = POS_W'($urandom_range(0, ring_fill - 1));
    return w;
  endfunction

  function automatic void steer_trend();
    case (trend)
      TREND_GROW: begin
        if (ring_fill == CAP && $urandom_range(0, 3) == 0) trend = TREND_SHRINK;
      end
      TREND_SHRINK: begin
        if (ring_fill == 0 && $urandom_range(0, 3) == 0)
          trend = $urandom_range(0, 1) ? TREND_GROW : TREND_MIX;
      end
      default: begin
        if ($urandom_range(0, 149) == 0)
          trend = $urandom_range(0, 1) ? TREND_GROW : TREND_SHRINK;
      end
    endcase
  endfunction

  function automatic void add_probe(input logic [OP_W-1:0] op,
                                    input logic [ELEM_FW-1:0] elem,
                                    input logic [POS_W-1:0] pos,
                                    input bit fixed,
                                    input logic [ELEM_FW-1:0] want_elem,
                                    input logic [COUNT_FW-1:0] want_count,
                                    input logic [STATUS_W-1:0] want_status);
    probe_t p;
    p.word.op               = op;
    p.word.element_in       = elem;
    p.word.position         = pos;
    p.fixed                 = fixed;
    p.want.element_out      = want_elem;
    p.want.count_out        = want_count;
    p.want.status           = want_status;
    probe_q.push_back(p);
  endfunction

  task automatic report_miss(input string what, input logic [ELEM_FW-1:0] got,
                             input logic [ELEM_FW-1:0] want);
    if (miss_cnt < PRINT_CAP)
      $display("mismatch on %s at response %0d: got %0h, want %0h",
               what, checked_cnt, got, want);
    miss_cnt++;
  endtask

  // Holds the word until it is taken, then records what it should return.
  task automatic offer_word(input bdel_pkg::req_word_t w, input bit fixed,
                            input bdel_pkg::rsp_word_t typed, input bit steady);
    bdel_pkg::rsp_word_t want;
    int                  gap;
    req_word  <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = apply_list_op(w);
    pending_q.push_back(fixed ? typed : want);
    gap = pick_gap(steady);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Responses are sampled mid-cycle, so the sender's pushes at the edge are settled.
  always @(negedge clk) begin
    bdel_pkg::rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_q.size() == 0) begin
        report_miss("word with nothing pending", rsp_word.element_out, '0);
      end else begin
        want = pending_q.pop_front();
        if (rsp_word.element_out !== want.element_out)
          report_miss("element_out", rsp_word.element_out, want.element_out);
        if (rsp_word.count_out !== want.count_out)
          report_miss("count_out", ELEM_FW'(rsp_word.count_out), ELEM_FW'(want.count_out));
        if (rsp_word.status !== want.status)
          report_miss("status", ELEM_FW'(rsp_word.status), ELEM_FW'(want.status));
      end
      checked_cnt++;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up.
  initial begin
    bit held_off;
    bit steady;
    int gap;
    held_off = 1'b0;
    steady   = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_off && checked_cnt >= HOLD_AFTER) begin
        held_off = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 29) == 0) steady = !steady;
        gap = pick_gap(steady);
        if (gap > 0) begin
          rsp_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    probe_t              p;
    bdel_pkg::rsp_word_t none;
    bit                  steady;
    none   = '0;
    steady = 1'b0;

    // Empty list, the unused code, both ends, and reads out of range.
    add_probe(bdel_pkg::OP_RD_HEAD,  '0, '0, 1, '0, 9'd0, bdel_pkg::ST_EMPTY);
    add_probe(bdel_pkg::OP_RD_TAIL,  '0, '0, 1, '0, 9'd0, bdel_pkg::ST_EMPTY);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, '0, 1, '0, 9'd0, bdel_pkg::ST_EMPTY);
    add_probe(bdel_pkg::OP_RM_HEAD,  '0, '0, 1, '0, 9'd0, bdel_pkg::ST_EMPTY);
    add_probe(bdel_pkg::OP_RM_TAIL,  '0, '0, 1, '0, 9'd0, bdel_pkg::ST_EMPTY);
    add_probe(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_INS_TAIL, 32'hFFFF_FFFF, '0, 1, '0, 9'd1, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_INS_HEAD, 32'h0000_0000, 8'hFF, 1, '0, 9'd2, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_HEAD,  '0, '0, 1, '0, 9'd2, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_TAIL,  '0, '0, 1, 32'hFFFF_FFFF, 9'd2, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, 8'd1, 1, 32'hFFFF_FFFF, 9'd2, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, 8'd2, 1, '0, 9'd2, bdel_pkg::ST_RANGE);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, 8'hFF, 1, '0, 9'd2, bdel_pkg::ST_RANGE);
    add_probe(bdel_pkg::OP_INS_TAIL, 32'hA5A5_5A5A, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_INS_HEAD, 32'h8000_0001, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, 8'd2, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, 8'd3, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RM_HEAD,  '0, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RM_TAIL,  '0, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_TAIL,  '0, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RM_HEAD,  '0, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RM_TAIL,  '0, '0, 0, '0, 9'd0, bdel_pkg::ST_OK);
    add_probe(bdel_pkg::OP_RD_INDEX, '0, '0, 1, '0, 9'd0, bdel_pkg::ST_EMPTY);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    while (probe_q.size() != 0) begin
      p = probe_q.pop_front();
      offer_word(p.word, p.fixed, p.want, 1'b0);
    end

    // The random part starts by growing, so the list reaches capacity early.
    trend = TREND_GROW;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 79) == 0) steady = !steady;
      offer_word(draw_word(), 1'b0, none, steady);
      steer_trend();
    end
    req_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miss_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
